/* sv/sha1s_pkg.sv */
// ============================================================================
// sha1s_pkg
// Shared types and constants of the streaming SHA-1 hash unit.
// ============================================================================
package sha1s_pkg;

    // Block and digest geometry.
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int WADDR_W      = $clog2(BLOCK_WORDS);
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int WIDX_W       = WADDR_W + 1;
    localparam int DIDX_W       = 3;

    // Operation codes carried by an input transaction.
    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Initial chaining value.
    localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Round constants.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // First padding byte.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Requests from the message controller to the compression core.
    typedef struct packed {
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [31:0]        wr_data;
        logic               start;
        logic               restart;
    } core_cmd_t;

    // Status returned by the compression core.
    typedef struct packed {
        logic                             done;
        logic [DIGEST_WORDS-1:0][31:0]    chain;
    } core_status_t;

endpackage

/* sv/sha1s_if.sv */
// ============================================================================
// sha1s_if
// Valid/ready channels of the streaming SHA-1 hash unit.
// ============================================================================

// Input channel: one operation per transaction.
interface sha1s_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// Output channel: one digest word per transaction.
interface sha1s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

/* sv/sha1s_round_core.sv */
// ============================================================================
// sha1s_round_core
// SHA-1 compression core: block/schedule memories, one round per cycle,
// and the five chaining words.
// ============================================================================
module sha1s_round_core
    import sha1s_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  core_cmd_t    cmd,
    output core_status_t status
);

    typedef enum logic [1:0] {C_IDLE, C_PRIME, C_ROUND, C_ADD} cstate_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

    // Two copies of the block / schedule window, giving four read ports.
    logic [31:0] mem_a [BLOCK_WORDS];
    logic [31:0] mem_b [BLOCK_WORDS];

    cstate_t                       state_reg, state_next;
    logic [ROUND_W-1:0]            round_reg, round_next;
    logic [DIGEST_WORDS-1:0][31:0] chain_reg, chain_next;
    logic [DIGEST_WORDS-1:0][31:0] work_reg, work_next;
    logic                          done_reg, done_next;
    logic [31:0]                   rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;

    logic [ROUND_W-1:0] rn;
    logic [WADDR_W-1:0] addr_a0, addr_a1, addr_b0, addr_b1;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [31:0]        mem_wdata;
    logic [31:0]        w, f, k, tmp;

    // Read addresses for the round after the current one. Early rounds read the
    // block word itself; later rounds read taps t-3, t-8, t-14 and t-16.
    always_comb
    begin
        rn = (state_reg == C_ROUND) ? ROUND_W'(round_reg + 1'b1) : '0;
        if (rn < ROUND_W'(BLOCK_WORDS))
        begin
            addr_a0 = rn[WADDR_W-1:0];
        end
        else
        begin
            addr_a0 = rn[WADDR_W-1:0] + WADDR_W'(BLOCK_WORDS - 3);
        end
        addr_a1 = rn[WADDR_W-1:0] + WADDR_W'(BLOCK_WORDS - 8);
        addr_b0 = rn[WADDR_W-1:0] + WADDR_W'(BLOCK_WORDS - 14);
        addr_b1 = rn[WADDR_W-1:0];
    end

    // Round function of the current round.
    always_comb
    begin
        if (round_reg < ROUND_W'(BLOCK_WORDS))
        begin
            w = rd_a0_reg;
        end
        else
        begin
            w = rotl1(rd_a0_reg ^ rd_a1_reg ^ rd_b0_reg ^ rd_b1_reg);
        end
        if (round_reg < ROUND_W'(20))
        begin
            f = work_reg[3] ^ (work_reg[1] & (work_reg[2] ^ work_reg[3]));
            k = K_0;
        end
        else if (round_reg < ROUND_W'(40))
        begin
            f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k = K_1;
        end
        else if (round_reg < ROUND_W'(60))
        begin
            f = (work_reg[1] & (work_reg[2] | work_reg[3])) | (work_reg[2] & work_reg[3]);
            k = K_2;
        end
        else
        begin
            f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k = K_3;
        end
        tmp = rotl5(work_reg[0]) + f + work_reg[4] + k + w;
    end

    // Sequencer: reload the chain on restart, prime the first read, run the rounds, add into the chain.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        done_next  = 1'b0;
        mem_we     = cmd.wr_en;
        mem_waddr  = cmd.wr_addr;
        mem_wdata  = cmd.wr_data;
        unique case (state_reg)
            C_IDLE:
            begin
                if (cmd.restart)
                begin
                    chain_next = H_INIT;
                end
                if (cmd.start)
                begin
                    state_next = C_PRIME;
                end
            end
            C_PRIME:
            begin
                work_next  = chain_reg;
                round_next = '0;
                state_next = C_ROUND;
            end
            C_ROUND:
            begin
                work_next[4] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = rotl30(work_reg[1]);
                work_next[1] = work_reg[0];
                work_next[0] = tmp;
                if (round_reg >= ROUND_W'(BLOCK_WORDS))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = round_reg[WADDR_W-1:0];
                    mem_wdata = w;
                end
                round_next = ROUND_W'(round_reg + 1'b1);
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Control state and chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            chain_reg <= H_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
            done_reg  <= done_next;
        end
    end

    // Working variables carry no reset.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    // Memories: one shared write, registered reads.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_a[mem_waddr] <= mem_wdata;
            mem_b[mem_waddr] <= mem_wdata;
        end
        rd_a0_reg <= mem_a[addr_a0];
        rd_a1_reg <= mem_a[addr_a1];
        rd_b0_reg <= mem_b[addr_b0];
        rd_b1_reg <= mem_b[addr_b1];
    end

    assign status.done  = done_reg;
    assign status.chain = chain_reg;

endmodule

/* sv/sha1_stream_hash_unit.sv */
// ============================================================================
// sha1_stream_hash_unit
// Streaming SHA-1: absorbs message bytes, pads on finish, emits the digest.
// ============================================================================
// The byte that completes a 64-byte block holds the input off while the
// compression core runs its 80 rounds, one per cycle, reading the schedule
// window from two copies of a 16-word memory. Finish writes the padding one
// word per cycle, runs one or two compressions and hands the digest to an
// output buffer that sends five word transactions, most significant word
// first; new bytes are taken while those words drain.
module sha1_stream_hash_unit
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha1s_in_if.sink    in_ch,
    sha1s_out_if.source out_ch
);

    typedef enum logic [2:0] {S_IDLE, S_ZERO, S_LEN, S_WAIT, S_DRAIN} state_t;
    typedef enum logic [1:0] {RET_IDLE, RET_PAD, RET_EMIT} ret_t;

    // Place one byte into a word under assembly; a word's first byte clears it.
    function automatic logic [31:0] put_byte(input logic [31:0] acc,
                                             input logic [1:0]  pos,
                                             input logic [7:0]  b);
        logic [31:0] word;
        word = acc;
        unique case (pos)
            2'd0: word = {b, 24'h000000};
            2'd1: word[23:16] = b;
            2'd2: word[15:8]  = b;
            2'd3: word[7:0]   = b;
            default: word = acc;
        endcase
        put_byte = word;
    endfunction

    state_t                        state_reg, state_next;
    ret_t                          ret_reg, ret_next;
    logic [5:0]                    off_reg, off_next;
    logic [63:0]                   len_reg, len_next;
    logic [63:0]                   bits_reg, bits_next;
    logic [31:0]                   acc_reg, acc_next;
    logic [WIDX_W-1:0]             widx_reg, widx_next;
    logic                          over_reg, over_next;
    logic [DIGEST_WORDS-1:0][31:0] digest_reg, digest_next;
    logic                          out_valid_reg, out_valid_next;
    logic [DIDX_W-1:0]             out_idx_reg, out_idx_next;

    logic         accept;
    core_cmd_t    cmd;
    core_status_t status;

    sha1s_round_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // Message controller and digest output buffer.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        bits_next      = bits_reg;
        acc_next       = acc_reg;
        widx_next      = widx_reg;
        over_next      = over_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        cmd            = '0;

        // Send digest words.
        if (out_valid_reg && out_ch.ready)
        begin
            if (out_idx_reg == DIDX_W'(DIGEST_WORDS - 1))
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                out_idx_next = DIDX_W'(out_idx_reg + 1'b1);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.operation)
                        OP_ABSORB:
                        begin
                            acc_next = put_byte(acc_reg, off_reg[1:0], in_ch.data_byte);
                            if (off_reg[1:0] == 2'd3)
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = off_reg[5:2];
                                cmd.wr_data = acc_next;
                            end
                            off_next = 6'(off_reg + 1'b1);
                            len_next = 64'(len_reg + 1'b1);
                            if (off_reg == 6'd63)
                            begin
                                cmd.start  = 1'b1;
                                ret_next   = RET_IDLE;
                                state_next = S_WAIT;
                            end
                        end
                        OP_FINISH:
                        begin
                            bits_next   = {len_reg[60:0], 3'b000};
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = off_reg[5:2];
                            cmd.wr_data = put_byte(acc_reg, off_reg[1:0], PAD_BYTE);
                            widx_next   = WIDX_W'({1'b0, off_reg[5:2]} + 1'b1);
                            over_next   = (off_reg[5:2] >= WADDR_W'(BLOCK_WORDS - 2));
                            off_next    = '0;
                            len_next    = '0;
                            state_next  = S_ZERO;
                        end
                        OP_RESTART:
                        begin
                            cmd.restart = 1'b1;
                            off_next    = '0;
                            len_next    = '0;
                        end
                        default:
                        begin
                            off_next = off_reg;
                        end
                    endcase
                end
            end
            S_ZERO:
            begin
                // Zero words up to the length field, or to the block end on overflow.
                if (!over_reg && widx_reg == WIDX_W'(BLOCK_WORDS - 2))
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = WADDR_W'(BLOCK_WORDS - 2);
                    cmd.wr_data = bits_reg[63:32];
                    state_next  = S_LEN;
                end
                else if (widx_reg == WIDX_W'(BLOCK_WORDS))
                begin
                    cmd.start  = 1'b1;
                    ret_next   = RET_PAD;
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = widx_reg[WADDR_W-1:0];
                    cmd.wr_data = '0;
                    widx_next   = WIDX_W'(widx_reg + 1'b1);
                end
            end
            S_LEN:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = WADDR_W'(BLOCK_WORDS - 1);
                cmd.wr_data = bits_reg[31:0];
                cmd.start   = 1'b1;
                ret_next    = RET_EMIT;
                state_next  = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.done)
                begin
                    unique case (ret_reg)
                        RET_IDLE:
                        begin
                            state_next = S_IDLE;
                        end
                        RET_PAD:
                        begin
                            widx_next  = '0;
                            over_next  = 1'b0;
                            state_next = S_ZERO;
                        end
                        RET_EMIT:
                        begin
                            state_next = S_DRAIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                // Hand the digest over once the buffer is free, then reinitialize.
                if (!out_valid_reg)
                begin
                    digest_next    = status.chain;
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    cmd.restart    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_IDLE;
            off_reg       <= '0;
            len_reg       <= '0;
            bits_reg      <= '0;
            acc_reg       <= '0;
            widx_reg      <= '0;
            over_reg      <= 1'b0;
            digest_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            off_reg       <= off_next;
            len_reg       <= len_next;
            bits_reg      <= bits_next;
            acc_reg       <= acc_next;
            widx_reg      <= widx_next;
            over_reg      <= over_next;
            digest_reg    <= digest_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.digest_word = digest_reg[out_idx_reg];
    assign out_ch.word_index  = out_idx_reg;
    assign out_ch.last_word   = (out_idx_reg == DIDX_W'(DIGEST_WORDS - 1));

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the streaming SHA-1 hash unit. A driver pushes
// operation transactions from a queue, a behavioral SHA-1 predictor runs on
// every accepted transaction, and a monitor checks each digest word in order.
// ============================================================================
module testbench
    import sha1s_pkg::*;
();

    // Operation code that the unit is expected to ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Predictor constants, kept apart from the design's own copies.
    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
    localparam logic [31:0] RK_0 = 32'h5A827999;
    localparam logic [31:0] RK_1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK_2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK_3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_FIRST = 8'h80;

    localparam int RANDOM_ITEMS = 125;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } hash_op_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sha1s_in_if  in_bus();
    sha1s_out_if out_bus();

    sha1_stream_hash_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hash_op_t     hash_ops_q[$];
    digest_word_t digest_words_q[$];

    // Predictor state.
    logic [31:0] chain [5];
    logic [31:0] blk_word [16];
    logic [5:0]  fill;
    logic [63:0] msg_bytes;

    int errors;
    int bytes_absorbed;
    int digests_predicted;
    int restarts_seen;
    int unused_seen;
    int words_checked;

    bit          src_calm;
    bit          snk_calm;
    int unsigned src_wait;
    int unsigned snk_wait;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Per-transaction idle count; calm stretches run with no idling.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned g;
        g = $urandom_range(0, 13);
        return calm ? 0 : g;
    endfunction

    function automatic void sha1_clear_message();
        chain[0] = IV_0;
        chain[1] = IV_1;
        chain[2] = IV_2;
        chain[3] = IV_3;
        chain[4] = IV_4;
        fill = '0;
        msg_bytes = '0;
    endfunction

    // 80-round compression of the current block into the chaining value.
    function automatic void sha1_compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, x, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk_word[i];
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
            begin
                x = w[r];
            end
            else
            begin
                x = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
                w[r % 16] = x;
            end
            if (r < 20)
            begin
                f = d ^ (b & (c ^ d));
                k = RK_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RK_1;
            end
            else if (r < 60)
            begin
                f = (b & (c | d)) | (c & d);
                k = RK_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK_3;
            end
            t = rotl(a, 5) + f + e + k + x;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // Big-endian byte placement; the first byte of a word clears the word.
    function automatic void sha1_load_byte(input logic [7:0] v);
        logic [4:0] sh;
        sh = {~fill[1:0], 3'b000};
        if (fill[1:0] == 2'd0)
            blk_word[fill[5:2]] = {24'h0, v} << sh;
        else
            blk_word[fill[5:2]] |= {24'h0, v} << sh;
        fill = fill + 6'd1;
        if (fill == 6'd0)
            sha1_compress_block();
    endfunction

    // Padding, length, final compression and the five expected digest words.
    function automatic void sha1_finish_message();
        logic [63:0]  bits;
        digest_word_t dw;
        bits = msg_bytes << 3;
        sha1_load_byte(PAD_FIRST);
        while (fill != 6'd56)
            sha1_load_byte(8'h00);
        blk_word[14] = bits[63:32];
        blk_word[15] = bits[31:0];
        fill = '0;
        sha1_compress_block();
        for (int i = 0; i < 5; i++)
        begin
            dw.word  = chain[i];
            dw.index = 3'(i);
            dw.last  = (i == 4);
            digest_words_q.push_back(dw);
        end
        digests_predicted++;
        sha1_clear_message();
    endfunction

    function automatic void sha1_apply(input hash_op_t op);
        unique case (op.operation)
            OP_ABSORB:
            begin
                sha1_load_byte(op.data_byte);
                // The byte count wraps at 2^64 by the width of the register.
                msg_bytes = msg_bytes + 64'd1;
                bytes_absorbed++;
            end
            OP_FINISH:  sha1_finish_message();
            OP_RESTART:
            begin
                sha1_clear_message();
                restarts_seen++;
            end
            default:    unused_seen++;
        endcase
    endfunction

    function automatic void queue_op(input logic [1:0] operation, input logic [7:0] data_byte);
        hash_op_t op;
        op.operation = operation;
        op.data_byte = data_byte;
        hash_ops_q.push_back(op);
    endfunction

    // Driver: predicts on every accepted transaction, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bus.valid     <= 1'b0;
            in_bus.operation <= OP_ABSORB;
            in_bus.data_byte <= 8'h00;
            src_wait         <= 0;
            src_calm         <= 1'b0;
            sha1_clear_message();
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
                sha1_apply(hash_op_t'{in_bus.operation, in_bus.data_byte});
            if (!in_bus.valid || in_bus.ready)
            begin
                if (src_wait != 0)
                begin
                    in_bus.valid <= 1'b0;
                    src_wait     <= src_wait - 1;
                end
                else if (hash_ops_q.size() != 0)
                begin
                    hash_op_t op;
                    op = hash_ops_q.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.operation <= op.operation;
                    in_bus.data_byte <= op.data_byte;
                    src_wait         <= pick_gap(src_calm);
                    if ($urandom_range(0, 23) == 0)
                        src_calm <= !src_calm;
                end
                else
                begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each digest word against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            snk_wait      <= 0;
            snk_calm      <= 1'b0;
        end
        else
        begin
            int unsigned  wait_next;
            digest_word_t exp;
            wait_next = snk_wait;
            if (out_bus.valid && out_bus.ready)
            begin
                words_checked++;
                if (digest_words_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word: expected none, actual %h idx %0d",
                             $time, out_bus.digest_word, out_bus.word_index);
                    errors++;
                end
                else
                begin
                    exp = digest_words_q.pop_front();
                    if (out_bus.digest_word !== exp.word)
                    begin
                        $display("%0t: digest_word: expected %h, actual %h",
                                 $time, exp.word, out_bus.digest_word);
                        errors++;
                    end
                    if (out_bus.word_index !== exp.index)
                    begin
                        $display("%0t: word_index: expected %0d, actual %0d",
                                 $time, exp.index, out_bus.word_index);
                        errors++;
                    end
                    if (out_bus.last_word !== exp.last)
                    begin
                        $display("%0t: last_word: expected %0b, actual %0b",
                                 $time, exp.last, out_bus.last_word);
                        errors++;
                    end
                end
                wait_next = pick_gap(snk_calm);
                if ($urandom_range(0, 15) == 0)
                    snk_calm <= !snk_calm;
            end
            if (wait_next != 0)
            begin
                out_bus.ready <= 1'b0;
                snk_wait      <= wait_next - 1;
            end
            else
            begin
                out_bus.ready <= 1'b1;
                snk_wait      <= 0;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int count;
        int len;
        int pick;
        in_bus.valid     = 1'b0;
        in_bus.operation = OP_ABSORB;
        in_bus.data_byte = 8'h00;
        out_bus.ready    = 1'b0;
        errors = 0;
        bytes_absorbed = 0;
        digests_predicted = 0;
        restarts_seen = 0;
        unused_seen = 0;
        words_checked = 0;

        // Empty message, then the classic three-byte message.
        queue_op(OP_FINISH, 8'hFF);
        queue_op(OP_ABSORB, 8'h61);
        queue_op(OP_ABSORB, 8'h62);
        queue_op(OP_ABSORB, 8'h63);
        queue_op(OP_FINISH, 8'h00);
        // Restart discards bytes; the unused code must change nothing.
        queue_op(OP_ABSORB, 8'h00);
        queue_op(OP_ABSORB, 8'hFF);
        queue_op(OP_UNUSED, 8'hA5);
        queue_op(OP_RESTART, 8'hFF);
        queue_op(OP_FINISH, 8'h00);
        // Byte extremes mixed with an ignored transaction inside a message.
        queue_op(OP_ABSORB, 8'hFF);
        queue_op(OP_ABSORB, 8'h00);
        queue_op(OP_ABSORB, 8'h80);
        queue_op(OP_UNUSED, 8'h5A);
        queue_op(OP_ABSORB, 8'h7F);
        queue_op(OP_FINISH, 8'hFF);
        // Restart on an empty message.
        queue_op(OP_RESTART, 8'h00);
        queue_op(OP_FINISH, 8'h00);

        // Random messages: mostly short, some around the padding boundary
        // and the full block, a few cut off by restart or sprinkled with noise.
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
                len = $urandom_range(55, 66);
            else if (pick < 25)
                len = $urandom_range(119, 129);
            else
                len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    queue_op(OP_UNUSED, 8'($urandom_range(0, 255)));
                queue_op(OP_ABSORB, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0)
                queue_op(OP_RESTART, 8'($urandom_range(0, 255)));
            else
                queue_op(OP_FINISH, 8'($urandom_range(0, 255)));
            count += len + 1;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (hash_ops_q.size() != 0 || in_bus.valid || digest_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d message bytes, %0d digests, %0d restarts, %0d ignored codes.",
                 bytes_absorbed, digests_predicted, restarts_seen, unused_seen);
        $display("%0d digest words checked, %0d errors.", words_checked, errors);
        if (errors == 0)
            $display("sha1_stream_hash_unit: match");
        else
            $display("sha1_stream_hash_unit: mismatch");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("Timeout with %0d transactions unsent and %0d digest words pending.",
                 hash_ops_q.size(), digest_words_q.size());
        $display("sha1_stream_hash_unit: mismatch");
        $finish;
    end

endmodule
